@@ hw/rtl/tqcs_pkg.sv @@
// Shared types, widths and codes of the telemetry quadratic coefficient search.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
package tqcs_pkg;

  // Fixed-point format of the target value.
  localparam int FRACTION_BITS = 8;
  localparam int VALUE_W       = 32;

  // Coefficient, sample and square widths.
  localparam int COEF_W = 8;
  localparam int X_W    = 8;
  localparam int XSQ_W  = 2 * X_W;
  localparam int MULT_W = XSQ_W + 1;
  localparam int PROD_W = COEF_W + MULT_W;

  // A polynomial value a*x*x + b*x + c with one guard bit.
  localparam int POLY_W  = PROD_W + 1;
  localparam int SHIFT_W = POLY_W + FRACTION_BITS;
  localparam int DIFF_W  = ((SHIFT_W > VALUE_W) ? SHIFT_W : VALUE_W) + 1;
  localparam int ERR_W   = DIFF_W - 1;

  // Scan limits of every coefficient.
  localparam logic signed [COEF_W-1:0] COEF_FIRST = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_LAST  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [X_W-1:0]           X_LAST     = {X_W{1'b1}};

  // Search phase of a candidate.
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic [X_W-1:0]            x_t;
  typedef logic [XSQ_W-1:0]          xsq_t;

  // One candidate issued by the sequencer to the shared unit.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic [1:0] phase;
    coef_t      coef;
    x_t         x;
    xsq_t       xsq;
  } cand_t;

  // Best fit found so far.
  typedef struct packed {
    coef_t coeff_a;
    coef_t coeff_b;
    coef_t coeff_c;
    x_t    raw_x;
  } fit_t;

endpackage

@@ hw/rtl/tqcs_in_if.sv @@
// Input channel of the coefficient search: one target value per beat.
// Depends on tqcs_pkg for the payload type.
interface tqcs_in_if;
  logic             valid;
  logic             ready;
  tqcs_pkg::value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ hw/rtl/tqcs_out_if.sv @@
// Result channel of the coefficient search: one fitted coefficient set per beat.
// Depends on tqcs_pkg for the payload types.
interface tqcs_out_if;
  logic            valid;
  logic            ready;
  tqcs_pkg::coef_t coeff_a;
  tqcs_pkg::coef_t coeff_b;
  tqcs_pkg::coef_t coeff_c;
  tqcs_pkg::x_t    raw_x;

  modport source (output valid, output coeff_a, output coeff_b, output coeff_c,
                  output raw_x, input ready);
  modport sink (input valid, input coeff_a, input coeff_b, input coeff_c,
                input raw_x, output ready);
endinterface

@@ hw/rtl/tqcs_eval.sv @@
// Shared multiply-add and error compare unit of the coefficient search.
// Depends on tqcs_pkg for widths, phase codes and the candidate struct.
module tqcs_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  tqcs_pkg::value_t  value_i,
  input  tqcs_pkg::cand_t   cand_i,
  output tqcs_pkg::fit_t    best_o
);

  tqcs_pkg::value_t                       target_r;
  logic signed [tqcs_pkg::POLY_W-1:0]     poly_r, poly_nxt;
  tqcs_pkg::cand_t                        pipe_r;
  logic signed [tqcs_pkg::POLY_W-1:0]     best_poly_r;
  logic signed [tqcs_pkg::POLY_W-1:0]     base_r;
  logic [tqcs_pkg::ERR_W-1:0]             best_err_r;
  tqcs_pkg::fit_t                         best_r;

  logic [tqcs_pkg::MULT_W-1:0]            mult;
  logic signed [tqcs_pkg::POLY_W-1:0]     base;
  logic signed [tqcs_pkg::PROD_W-1:0]     prod;
  logic signed [tqcs_pkg::DIFF_W-1:0]     diff;
  logic [tqcs_pkg::ERR_W-1:0]             err;
  logic                                   take;

  // The target is held for the whole search.
  always_ff @(posedge clk) begin
    if (load_i) begin
      target_r <= value_i;
    end
  end

  // The base of a phase is the best polynomial of the phase before it. It is taken
  // straight from the best register for the first candidate and frozen after that,
  // because candidates taken within the phase overwrite the best register.
  always_ff @(posedge clk) begin
    if (cand_i.valid && cand_i.first) begin
      base_r <= best_poly_r;
    end
  end

  // Operand selection: a scales x*x, b scales x, c is added as it is.
  always_comb begin
    case (cand_i.phase)
      tqcs_pkg::PH_A: begin
        mult = {1'b0, cand_i.xsq};
        base = '0;
      end
      tqcs_pkg::PH_B: begin
        mult = tqcs_pkg::MULT_W'(best_r.raw_x);
        base = cand_i.first ? best_poly_r : base_r;
      end
      default: begin
        mult = tqcs_pkg::MULT_W'(1);
        base = cand_i.first ? best_poly_r : base_r;
      end
    endcase
    prod     = cand_i.coef * $signed(mult);
    poly_nxt = base + tqcs_pkg::POLY_W'(prod);
  end

  // First stage: the candidate's polynomial value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else begin
      pipe_r.valid <= cand_i.valid;
    end
    pipe_r.first <= cand_i.first;
    pipe_r.phase <= cand_i.phase;
    pipe_r.coef  <= cand_i.coef;
    pipe_r.x     <= cand_i.x;
    pipe_r.xsq   <= cand_i.xsq;
    poly_r       <= poly_nxt;
  end

  // Second stage: exact absolute error against the target.
  always_comb begin
    diff = (tqcs_pkg::DIFF_W'(poly_r) <<< tqcs_pkg::FRACTION_BITS)
           - tqcs_pkg::DIFF_W'(target_r);
    if (diff[tqcs_pkg::DIFF_W-1]) begin
      err = tqcs_pkg::ERR_W'(-diff);
    end else begin
      err = tqcs_pkg::ERR_W'(diff);
    end
    take = pipe_r.valid && (pipe_r.first || (err < best_err_r));
  end

  // The first candidate of a phase always opens it; later ones must be strictly better.
  always_ff @(posedge clk) begin
    if (take) begin
      best_err_r  <= err;
      best_poly_r <= poly_r;
      case (pipe_r.phase)
        tqcs_pkg::PH_A: begin
          best_r.coeff_a <= pipe_r.coef;
          best_r.raw_x   <= pipe_r.x;
        end
        tqcs_pkg::PH_B: begin
          best_r.coeff_b <= pipe_r.coef;
        end
        default: begin
          best_r.coeff_c <= pipe_r.coef;
        end
      endcase
    end
  end

  assign best_o = best_r;

endmodule

@@ hw/rtl/tqcs_seq.sv @@
// Sequencer of the coefficient search: walks the three scans and issues candidates.
// Depends on tqcs_pkg for widths, scan limits, phase codes and the candidate struct.
module tqcs_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  logic            out_free_i,
  output logic            in_ready_o,
  output logic            done_o,
  output tqcs_pkg::cand_t cand_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN_A = 3'd1;
  localparam logic [2:0] ST_WAIT_A = 3'd2;
  localparam logic [2:0] ST_SCAN_B = 3'd3;
  localparam logic [2:0] ST_WAIT_B = 3'd4;
  localparam logic [2:0] ST_SCAN_C = 3'd5;
  localparam logic [2:0] ST_WAIT_C = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]          state_r, state_nxt;
  tqcs_pkg::coef_t     k_r, k_nxt;
  tqcs_pkg::x_t        x_r, x_nxt;
  tqcs_pkg::xsq_t      xsq_r, xsq_nxt;

  logic k_first, k_last;

  assign k_first = (k_r == tqcs_pkg::COEF_FIRST);
  assign k_last  = (k_r == tqcs_pkg::COEF_LAST);

  // Next state and scan counters; the wait states let the last candidate settle.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    xsq_nxt   = xsq_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          state_nxt = ST_SCAN_A;
          k_nxt     = tqcs_pkg::COEF_FIRST;
          x_nxt     = '0;
          xsq_nxt   = '0;
        end
      end
      ST_SCAN_A: begin
        if (k_last && (x_r == tqcs_pkg::X_LAST)) begin
          state_nxt = ST_WAIT_A;
        end else if (k_first || (x_r == tqcs_pkg::X_LAST)) begin
          // The lowest a is tried at x = 0 only.
          k_nxt   = k_r + 1'b1;
          x_nxt   = '0;
          xsq_nxt = '0;
        end else begin
          x_nxt   = x_r + 1'b1;
          xsq_nxt = xsq_r + {{(tqcs_pkg::X_W-1){1'b0}}, x_r, 1'b1};
        end
      end
      ST_WAIT_A: begin
        state_nxt = ST_SCAN_B;
        k_nxt     = tqcs_pkg::COEF_FIRST;
      end
      ST_SCAN_B: begin
        if (k_last) begin
          state_nxt = ST_WAIT_B;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_WAIT_B: begin
        state_nxt = ST_SCAN_C;
        k_nxt     = tqcs_pkg::COEF_FIRST;
      end
      ST_SCAN_C: begin
        if (k_last) begin
          state_nxt = ST_WAIT_C;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_WAIT_C: begin
        state_nxt = ST_FIN;
      end
      default: begin
        if (out_free_i) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r   <= k_nxt;
    x_r   <= x_nxt;
    xsq_r <= xsq_nxt;
  end

  // Candidate issued to the shared unit.
  always_comb begin
    cand_o.valid = (state_r == ST_SCAN_A) || (state_r == ST_SCAN_B)
                   || (state_r == ST_SCAN_C);
    cand_o.first = k_first;
    cand_o.coef  = k_r;
    cand_o.x     = x_r;
    cand_o.xsq   = xsq_r;
    case (state_r)
      ST_SCAN_B: cand_o.phase = tqcs_pkg::PH_B;
      ST_SCAN_C: cand_o.phase = tqcs_pkg::PH_C;
      default:   cand_o.phase = tqcs_pkg::PH_A;
    endcase
  end

  assign in_ready_o = (state_r == ST_IDLE);
  assign done_o     = (state_r == ST_FIN) && out_free_i;

endmodule

@@ hw/rtl/telemetry_quadratic_coeff_search_top.sv @@
// Top level of the telemetry quadratic coefficient search.
// Depends on tqcs_pkg, tqcs_in_if, tqcs_out_if, tqcs_seq and tqcs_eval.

// Each beat on in_ch carries a signed Q24.8 target; the block fits it greedily to
// a*x*x + b*x + c and returns one beat on out_ch with a, b, c and x. The block takes
// one target at a time: between the accepting beat and the result it walks 65281
// candidates for a and x, 256 for b and 256 for c, with a settle state after each
// scan and a final state that loads the result, because one shared multiply-add
// and error compare unit evaluates one candidate per cycle. The next beat is
// accepted only once the sequencer is back in its idle state. A result waits in an
// output register, so the next target is accepted while the previous result is not yet taken.
module telemetry_quadratic_coeff_search_top (
  input  logic        clk,
  input  logic        rst_n,
  tqcs_in_if.sink     in_ch,
  tqcs_out_if.source  out_ch
);

  tqcs_pkg::cand_t cand;
  tqcs_pkg::fit_t  best;
  logic            start, out_free, done, in_ready;
  logic            out_valid_r, out_valid_nxt;
  tqcs_pkg::fit_t  out_r;

  assign start    = in_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;

  tqcs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .done_o     (done),
    .cand_o     (cand)
  );

  tqcs_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (in_ch.valid && in_ready),
    .value_i (in_ch.value),
    .cand_i  (cand),
    .best_o  (best)
  );

  assign in_ch.ready = in_ready;

  // Output register: loaded when a search ends, cleared when its beat is taken.
  always_comb begin
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (done) begin
      out_r <= best;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.coeff_a = out_r.coeff_a;
  assign out_ch.coeff_b = out_r.coeff_b;
  assign out_ch.coeff_c = out_r.coeff_c;
  assign out_ch.raw_x   = out_r.raw_x;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for telemetry_quadratic_coeff_search_top: it drives Q24.8 targets,
// predicts each greedy a*x*x + b*x + c fit and checks every result beat field by field.
// Depends on tqcs_pkg, tqcs_in_if, tqcs_out_if and the top level of the block.
module tb_top;
  import tqcs_pkg::*;

  localparam int HOLD_AFTER   = 4;       // results seen before the long hold-off starts
  localparam int HOLD_CYCLES  = 160000;  // longer than two full searches
  localparam int DRAIN_CYCLES = 66000;   // about one search latency
  localparam int N_RANDOM     = 90;

  typedef struct {
    value_t value;
    bit     settle_first;
  } target_item_t;

  logic clk;
  logic rst_n;

  tqcs_in_if  in_bus ();
  tqcs_out_if out_bus ();

  telemetry_quadratic_coeff_search_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  target_item_t pending_targets[$];
  fit_t         expected_fits[$];

  int unsigned accepted_cnt;
  int unsigned results_cnt;
  int unsigned fail_cnt;
  int unsigned settle_pauses;
  int unsigned n_directed;
  int          burst_left;
  int          gap_left;
  int          mode_left;
  int          stall_odds;
  logic        hold_on;
  logic        hold_done;
  int          hold_left;

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Absolute error of an integer polynomial value against the fixed-point target.
  function automatic longint fit_err(longint poly, longint tgt);
    longint d;
    d = (poly <<< FRACTION_BITS) - tgt;
    return (d < 0) ? -d : d;
  endfunction

  // Greedy three-stage search: a and x first, then b, then c; ties keep the earlier one.
  function automatic fit_t best_fit(value_t target);
    longint tgt, top, e, base;
    longint a, x, b, c;
    longint a_best, x_best, b_best, c_best;
    fit_t   fit;
    tgt    = longint'(target);
    a_best = -128;
    x_best = 0;
    b_best = -128;
    c_best = -128;
    top = fit_err(a_best * x_best * x_best, tgt);
    for (a = -127; a < 128; a++) begin
      for (x = 0; x < 256; x++) begin
        e = fit_err(a * x * x, tgt);
        if (e < top) begin
          top    = e;
          a_best = a;
          x_best = x;
        end
      end
    end
    base = a_best * x_best * x_best;
    top  = fit_err(base + b_best * x_best, tgt);
    for (b = -127; b < 128; b++) begin
      e = fit_err(base + b * x_best, tgt);
      if (e < top) begin
        top    = e;
        b_best = b;
      end
    end
    base = base + b_best * x_best;
    top  = fit_err(base + c_best, tgt);
    for (c = -127; c < 128; c++) begin
      e = fit_err(base + c, tgt);
      if (e < top) begin
        top    = e;
        c_best = c;
      end
    end
    fit.coeff_a = a_best[COEF_W-1:0];
    fit.coeff_b = b_best[COEF_W-1:0];
    fit.coeff_c = c_best[COEF_W-1:0];
    fit.raw_x   = x_best[X_W-1:0];
    return fit;
  endfunction

  // Random target: exact polynomial values, some with fraction noise, plus
  // full-range, small and near-extreme values.
  function automatic value_t random_target();
    longint a, x, b, c, v;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      a = longint'($urandom_range(0, 254)) - 127;
      x = $urandom_range(0, 1) ? longint'($urandom_range(0, 255)) : longint'($urandom_range(0, 15));
      b = longint'($urandom_range(0, 255)) - 128;
      c = longint'($urandom_range(0, 255)) - 128;
      v = (a * x * x + b * x + c) <<< FRACTION_BITS;
      if ($urandom_range(0, 2) == 0) v = v + longint'($urandom_range(0, 255));
      return value_t'(v);
    end else if (pick < 70) begin
      return value_t'($urandom());
    end else if (pick < 85) begin
      return value_t'(longint'($urandom_range(0, 131072)) - 65536);
    end else if ($urandom_range(0, 1) == 1) begin
      return value_t'(32'h7E00_0000 | $urandom_range(0, 32'h01FF_FFFF));
    end
    return value_t'(32'h8000_0000 | $urandom_range(0, 32'h01FF_FFFF));
  endfunction

  task automatic add_target(input value_t v, input bit settle);
    target_item_t item;
    item.value        = v;
    item.settle_first = settle;
    pending_targets.push_back(item);
  endtask

  // One line per mismatch, and a count for the final verdict.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH beat %0d: %s got %0d, expected %0d", results_cnt, what, got, want);
    fail_cnt++;
  endtask

  // Sender: bursts of random length separated by random gaps; an item flagged to
  // settle first is held back until every earlier result has come out.
  always @(posedge clk) begin
    target_item_t item;
    logic         offer;
    int unsigned  done_now;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.value <= '0;
      accepted_cnt <= 0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      done_now = accepted_cnt;
      offer    = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        expected_fits.push_back(best_fit(in_bus.value));
        done_now++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_targets.size() != 0 &&
                     (!pending_targets[0].settle_first || done_now == results_cnt)) begin
          item = pending_targets.pop_front();
          in_bus.value <= item.value;
          offer = 1'b1;
          if (item.settle_first) settle_pauses++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 5);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      accepted_cnt <= done_now;
      in_bus.valid <= offer;
    end
  end

  // Long hold-off of the result channel, once, while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_on   <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (hold_on) begin
      if (hold_left == 1) hold_on <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_cnt == HOLD_AFTER) begin
      hold_on   <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: checks each result beat against the oldest prediction and stalls in
  // stretches of random density, including stretches with no stalls at all.
  always @(posedge clk) begin
    fit_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      results_cnt   <= 0;
      mode_left     = 0;
      stall_odds    = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_cnt <= results_cnt + 1;
        if (expected_fits.size() == 0) begin
          report_mismatch("unexpected beat, coeff_a", int'(out_bus.coeff_a), 0);
        end else begin
          want = expected_fits.pop_front();
          if (out_bus.coeff_a !== want.coeff_a)
            report_mismatch("coeff_a", int'(out_bus.coeff_a), int'(want.coeff_a));
          if (out_bus.coeff_b !== want.coeff_b)
            report_mismatch("coeff_b", int'(out_bus.coeff_b), int'(want.coeff_b));
          if (out_bus.coeff_c !== want.coeff_c)
            report_mismatch("coeff_c", int'(out_bus.coeff_c), int'(want.coeff_c));
          if (out_bus.raw_x !== want.raw_x)
            report_mismatch("raw_x", int'(out_bus.raw_x), int'(want.raw_x));
        end
      end
      if (mode_left == 0) begin
        mode_left  = $urandom_range(16, 400);
        stall_odds = $urandom_range(0, 3);
      end else begin
        mode_left--;
      end
      out_bus.ready <= !hold_on && ($urandom_range(0, 3) >= stall_odds);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int i;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.value   = '0;
    out_bus.ready  = 1'b0;
    fail_cnt       = 0;
    settle_pauses  = 0;

    // Directed targets: zero, unit steps, a half-way tie, field extremes,
    // the largest reachable magnitudes and one exact polynomial.
    add_target(value_t'(0), 1'b0);
    add_target(value_t'(1), 1'b0);
    add_target(value_t'(-1), 1'b0);
    add_target(value_t'(128), 1'b0);
    add_target(value_t'(-128), 1'b0);
    add_target(value_t'(256), 1'b0);
    add_target(value_t'(-256), 1'b0);
    add_target(value_t'(384), 1'b0);
    add_target(value_t'(32'h7FFF_FFFF), 1'b1);
    add_target(value_t'(32'h8000_0000), 1'b0);
    add_target(value_t'(longint'(127 * 255 * 255) <<< FRACTION_BITS), 1'b0);
    add_target(value_t'(-(longint'(127 * 255 * 255) <<< FRACTION_BITS)), 1'b0);
    add_target(value_t'(longint'(3 * 10 * 10 - 5 * 10 + 7) <<< FRACTION_BITS), 1'b0);
    add_target(value_t'(32'h5555_5555), 1'b0);
    add_target(value_t'(32'hAAAA_AAAA), 1'b0);
    n_directed = pending_targets.size();

    for (i = 0; i < N_RANDOM; i++) add_target(random_target(), i == N_RANDOM / 2);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_targets.size() != 0 || in_bus.valid || accepted_cnt != results_cnt);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_fits.size() != 0)
      report_mismatch("results never returned", 0, expected_fits.size());

    $display("Covered %0d directed and %0d random targets; %0d fits checked field by field.",
             n_directed, N_RANDOM, results_cnt);
    $display("Result channel held off once for %0d cycles; input paused %0d times to drain.",
             HOLD_CYCLES, settle_pauses);
    if (fail_cnt == 0) begin
      $display("** telemetry_quadratic_coeff_search_top: PASSED **");
    end else begin
      $display("** telemetry_quadratic_coeff_search_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #400_000_000;
    $display("Timeout: %0d targets accepted, %0d results seen.", accepted_cnt, results_cnt);
    $display("** telemetry_quadratic_coeff_search_top: FAILED **");
    $finish;
  end

endmodule
